@@ rtl/psp_pkg.sv @@
// shared constants and codes for the multi-page shelf packer
package psp_pkg;

    // default geometry
    localparam int PAGE_SIDE_DEF = 2048;
    localparam int MAX_PAGES_DEF = 16;

    // field widths
    localparam int IMG_W    = 13;
    localparam int SIDE_W   = 11;
    localparam int STATUS_W = 2;
    localparam int PAGE_W   = 4;
    localparam int COORD_W  = 11;

    // reset value of the largest-side register
    localparam logic [SIDE_W-1:0] MAX_SIDE_RESET = 11'd512;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_PLACED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NEW    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BYPASS = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd3;

endpackage

@@ rtl/psp_ram.sv @@
// generic single-port-write, single-port-read ram with registered read data
module psp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/multi_page_shelf_packer.sv @@
// top level of the multi-page shelf packer: sequencer, page walk and result register
//
// Usage:
//   s_tvalid/s_tready/s_tdata carry one request per transaction: image width and
//   height. m_tvalid/m_tready/m_tdata/m_tuser return one result per request:
//   tuser holds the status, tdata the page index and the inner x/y corner.
//   cfg_wen/cfg_wdata write the largest accepted image side (reset 512); write
//   it only while no request is in flight.
// Flow:
//   an oversized request is rejected in S_CHECK; otherwise S_EVAL visits the open
//   pages in order and places the box on the first that fits, and S_NEW opens a
//   page or reports none left; the page table ram gives one entry a cycle.
//   s_tready rises as the result loads, so a new request is accepted only once
//   the result of the last one has left the sequencer.
// Reset:
//   aresetn (synchronous, active low) closes all pages and restores the register.
//   the page table is not cleared: entries are only used below the open count.
// Stall:
//   the result register holds while m_tready is low; one more request can be
//   accepted and worked on, and it waits until the result register frees up.
module multi_page_shelf_packer #(
    parameter int PAGE_SIDE = psp_pkg::PAGE_SIDE_DEF,
    parameter int MAX_PAGES = psp_pkg::MAX_PAGES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // request channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // img_width[12:0], img_height[25:13], zero pad
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // page_index[3:0], atlas_x[14:4], atlas_y[25:15], pad
    output logic [1:0]  m_tuser,   // status[1:0]
    // configuration
    input  logic        cfg_wen,
    input  logic [10:0] cfg_wdata
);

    localparam int CW = $clog2(PAGE_SIDE + 1);
    localparam int SW = CW + 2;
    localparam int PW = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam int NW = $clog2(MAX_PAGES + 1);
    localparam int EW = 3 * CW;
    localparam int IW = psp_pkg::IMG_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_EVAL,
        S_NEW
    } state_t;

    state_t state_reg, state_next;

    logic [psp_pkg::SIDE_W-1:0]   max_side_reg;
    logic [IW-1:0]                iw_reg, iw_next;
    logic [IW-1:0]                ih_reg, ih_next;
    logic [CW-1:0]                bw_reg, bw_next;
    logic [CW-1:0]                bh_reg, bh_next;
    logic [PW-1:0]                pg_reg, pg_next;
    logic [NW-1:0]                open_reg, open_next;
    logic                         res_pend_reg, res_pend_next;
    logic [psp_pkg::STATUS_W-1:0] res_st_reg, res_st_next;
    logic [psp_pkg::PAGE_W-1:0]   res_pg_reg, res_pg_next;
    logic [psp_pkg::COORD_W-1:0]  res_x_reg, res_x_next;
    logic [psp_pkg::COORD_W-1:0]  res_y_reg, res_y_next;
    logic                         m_valid_reg, m_valid_next;
    logic [psp_pkg::STATUS_W-1:0] m_st_reg, m_st_next;
    logic [psp_pkg::PAGE_W-1:0]   m_pg_reg, m_pg_next;
    logic [psp_pkg::COORD_W-1:0]  m_x_reg, m_x_next;
    logic [psp_pkg::COORD_W-1:0]  m_y_reg, m_y_next;

    // page table port
    logic          ram_we;
    logic [PW-1:0] ram_waddr;
    logic [EW-1:0] ram_wdata;
    logic [PW-1:0] ram_raddr;
    logic [EW-1:0] ram_rdata;

    // size check
    logic [IW+1:0] bw_full, bh_full;
    logic          too_large;

    // page evaluation unit
    logic [CW-1:0] cx, sy, sh;
    logic [SW-1:0] x_end, y_end, y_shelf, y_shelf_end;
    logic          moved, fit;
    logic [CW-1:0] eff_cx, eff_sy, eff_sh;
    logic [CW-1:0] new_cx, new_sh;
    logic          last_page, pages_full, out_free;

    psp_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_PAGES)
    ) u_page_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // oversized request check
    always_comb begin
        bw_full   = (IW + 2)'(iw_reg) + (IW + 2)'(2);
        bh_full   = (IW + 2)'(ih_reg) + (IW + 2)'(2);
        too_large = (iw_reg > IW'(max_side_reg)) || (ih_reg > IW'(max_side_reg)) ||
                    (bw_full > (IW + 2)'(PAGE_SIDE)) || (bh_full > (IW + 2)'(PAGE_SIDE));
    end

    // one page entry: shelf move, fit test and updated entry
    always_comb begin
        cx          = ram_rdata[CW-1:0];
        sy          = ram_rdata[2*CW-1:CW];
        sh          = ram_rdata[3*CW-1:2*CW];
        x_end       = SW'(cx) + SW'(bw_reg);
        y_end       = SW'(sy) + SW'(bh_reg);
        y_shelf     = SW'(sy) + SW'(sh);
        y_shelf_end = y_shelf + SW'(bh_reg);
        moved       = (x_end > SW'(PAGE_SIDE)) && (y_shelf_end <= SW'(PAGE_SIDE));
        fit         = moved || ((x_end <= SW'(PAGE_SIDE)) && (y_end <= SW'(PAGE_SIDE)));
        eff_cx      = moved ? '0 : cx;
        eff_sy      = moved ? CW'(y_shelf) : sy;
        eff_sh      = moved ? '0 : sh;
        new_cx      = moved ? bw_reg : CW'(x_end);
        new_sh      = (bh_reg > eff_sh) ? bh_reg : eff_sh;
        last_page   = (NW'(pg_reg) + NW'(1)) == open_reg;
        pages_full  = open_reg == NW'(MAX_PAGES);
        out_free    = !m_valid_reg || m_tready;
    end

    // sequencer
    always_comb begin
        state_next    = state_reg;
        iw_next       = iw_reg;
        ih_next       = ih_reg;
        bw_next       = bw_reg;
        bh_next       = bh_reg;
        pg_next       = pg_reg;
        open_next     = open_reg;
        res_pend_next = res_pend_reg;
        res_st_next   = res_st_reg;
        res_pg_next   = res_pg_reg;
        res_x_next    = res_x_reg;
        res_y_next    = res_y_reg;
        ram_we        = 1'b0;
        ram_waddr     = pg_reg;
        ram_wdata     = {new_sh, eff_sy, new_cx};
        ram_raddr     = pg_reg + PW'(1);
        s_tready      = (state_reg == S_IDLE) && !res_pend_reg;

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid && s_tready) begin
                    iw_next    = s_tdata[IW-1:0];
                    ih_next    = s_tdata[2*IW-1:IW];
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                bw_next   = CW'(bw_full);
                bh_next   = CW'(bh_full);
                pg_next   = '0;
                ram_raddr = '0;
                if (too_large) begin
                    res_pend_next = 1'b1;
                    res_st_next   = psp_pkg::ST_BYPASS;
                    res_pg_next   = '0;
                    res_x_next    = '0;
                    res_y_next    = '0;
                    state_next    = S_IDLE;
                end else if (open_reg == '0) begin
                    state_next = S_NEW;
                end else begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL: begin
                // a move always lands the box, so entries change only on a fit
                if (fit) begin
                    ram_we        = 1'b1;
                    res_pend_next = 1'b1;
                    res_st_next   = psp_pkg::ST_PLACED;
                    res_pg_next   = psp_pkg::PAGE_W'(pg_reg);
                    res_x_next    = psp_pkg::COORD_W'(eff_cx + CW'(1));
                    res_y_next    = psp_pkg::COORD_W'(eff_sy + CW'(1));
                    state_next    = S_IDLE;
                end else if (last_page) begin
                    state_next = S_NEW;
                end else begin
                    pg_next = pg_reg + PW'(1);
                end
            end
            S_NEW: begin
                res_pend_next = 1'b1;
                if (pages_full) begin
                    res_st_next = psp_pkg::ST_FULL;
                    res_pg_next = '0;
                    res_x_next  = '0;
                    res_y_next  = '0;
                end else begin
                    ram_we      = 1'b1;
                    ram_waddr   = PW'(open_reg);
                    ram_wdata   = {bh_reg, CW'(0), bw_reg};
                    open_next   = open_reg + NW'(1);
                    res_st_next = psp_pkg::ST_NEW;
                    res_pg_next = psp_pkg::PAGE_W'(open_reg);
                    res_x_next  = psp_pkg::COORD_W'(1);
                    res_y_next  = psp_pkg::COORD_W'(1);
                end
                state_next = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output register: takes the pending result when the slot is free
    always_comb begin
        m_valid_next = m_valid_reg && !m_tready;
        m_st_next    = m_st_reg;
        m_pg_next    = m_pg_reg;
        m_x_next     = m_x_reg;
        m_y_next     = m_y_reg;
        if (res_pend_reg && out_free) begin
            m_valid_next = 1'b1;
            m_st_next    = res_st_reg;
            m_pg_next    = res_pg_reg;
            m_x_next     = res_x_reg;
            m_y_next     = res_y_reg;
        end
    end

    // state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            open_reg     <= '0;
            res_pend_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            max_side_reg <= psp_pkg::MAX_SIDE_RESET;
        end else begin
            state_reg    <= state_next;
            open_reg     <= open_next;
            res_pend_reg <= res_pend_next && !(res_pend_reg && out_free);
            m_valid_reg  <= m_valid_next;
            if (cfg_wen) begin
                max_side_reg <= cfg_wdata;
            end
        end
        iw_reg     <= iw_next;
        ih_reg     <= ih_next;
        bw_reg     <= bw_next;
        bh_reg     <= bh_next;
        pg_reg     <= pg_next;
        res_st_reg <= res_st_next;
        res_pg_reg <= res_pg_next;
        res_x_reg  <= res_x_next;
        res_y_reg  <= res_y_next;
        m_st_reg   <= m_st_next;
        m_pg_reg   <= m_pg_next;
        m_x_reg    <= m_x_next;
        m_y_reg    <= m_y_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_st_reg;
    assign m_tdata  = {6'd0, m_y_reg, m_x_reg, m_pg_reg};

    // open page count never passes the page budget
    a_open_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        open_reg <= NW'(MAX_PAGES))
        else $error("open page count above budget");

    // a request never produces a result in the cycle right after acceptance
    a_min_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !$rose(m_valid_reg))
        else $error("result too early");

    // bypass and out-of-pages results carry zero coordinates
    a_reject_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (m_st_reg == psp_pkg::ST_BYPASS || m_st_reg == psp_pkg::ST_FULL))
        |-> (m_pg_reg == '0 && m_x_reg == '0 && m_y_reg == '0))
        else $error("rejected result with coordinates");

    // a fresh page always places at its inner corner
    a_new_corner: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_st_reg == psp_pkg::ST_NEW)
        |-> (m_x_reg == psp_pkg::COORD_W'(1) && m_y_reg == psp_pkg::COORD_W'(1)))
        else $error("new page not at corner");

endmodule

@@ tb/multi_page_shelf_packer_tb.sv @@
// self-checking testbench for the multi-page shelf packer with its own placement predictor
module multi_page_shelf_packer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PAGE_SIDE   = psp_pkg::PAGE_SIDE_DEF;
    localparam int MAX_PAGES   = psp_pkg::MAX_PAGES_DEF;
    localparam int STALL_LIMIT = 4000;
    localparam int HOLD_AT     = 400;
    localparam int HOLD_CYCLES = 300;

    // one request: width in the low bits, height above it
    typedef struct packed {
        bit [psp_pkg::IMG_W-1:0] height;
        bit [psp_pkg::IMG_W-1:0] width;
    } image_req_t;

    // one placement result
    typedef struct {
        logic [psp_pkg::STATUS_W-1:0] status;
        logic [psp_pkg::PAGE_W-1:0]   page;
        logic [psp_pkg::COORD_W-1:0]  x;
        logic [psp_pkg::COORD_W-1:0]  y;
    } placement_t;

    logic        aclk;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        cfg_wen   = 1'b0;
    logic [10:0] cfg_wdata = '0;

    multi_page_shelf_packer #(
        .PAGE_SIDE(PAGE_SIDE),
        .MAX_PAGES(MAX_PAGES)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_wen  (cfg_wen),
        .cfg_wdata(cfg_wdata)
    );

    // clock, 12 ns period
    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    // predictor state: largest side and per-page shelf bookkeeping
    bit [psp_pkg::SIDE_W-1:0] side_limit = psp_pkg::MAX_SIDE_RESET;
    bit [11:0]       page_cursor    [MAX_PAGES];
    bit [11:0]       page_shelf_top [MAX_PAGES];
    bit [11:0]       page_shelf_h   [MAX_PAGES];
    bit [4:0]        pages_used = '0;

    image_req_t image_requests[$];
    placement_t pending_results[$];
    image_req_t cur_req;
    placement_t want_res;
    bit         failed = 1'b0;
    int         cyc = 0;
    int         quiet = 0;
    int         results_seen = 0;
    int         hold_cnt = 0;
    bit         hold_done = 1'b0;

    // first-fit shelf placement of one image, updating the page table
    function automatic placement_t place_image(image_req_t req);
        placement_t res;
        int         bw;
        int         bh;
        int         p;
        int         tmp;
        bit         hit;
        bw = int'(req.width) + 2;
        bh = int'(req.height) + 2;
        res.status = psp_pkg::ST_BYPASS;
        res.page   = '0;
        res.x      = '0;
        res.y      = '0;
        if (req.width > side_limit || req.height > side_limit ||
            bw > PAGE_SIDE || bh > PAGE_SIDE)
            return res;
        hit = 1'b0;
        p = 0;
        while (!hit && p < int'(pages_used)) begin
            // row full: open a new shelf below if it has height left
            if (int'(page_cursor[p]) + bw > PAGE_SIDE &&
                int'(page_shelf_top[p]) + int'(page_shelf_h[p]) + bh <= PAGE_SIDE) begin
                page_shelf_top[p] = page_shelf_top[p] + page_shelf_h[p];
                page_cursor[p]    = '0;
                page_shelf_h[p]   = '0;
            end
            if (int'(page_cursor[p]) + bw <= PAGE_SIDE &&
                int'(page_shelf_top[p]) + bh <= PAGE_SIDE)
                hit = 1'b1;
            else
                p++;
        end
        if (!hit) begin
            if (int'(pages_used) >= MAX_PAGES) begin
                res.status = psp_pkg::ST_FULL;
                return res;
            end
            p = int'(pages_used);
            pages_used++;
            page_cursor[p]    = '0;
            page_shelf_top[p] = '0;
            page_shelf_h[p]   = '0;
            res.status = psp_pkg::ST_NEW;
        end else begin
            res.status = psp_pkg::ST_PLACED;
        end
        res.page = p[psp_pkg::PAGE_W-1:0];
        tmp = int'(page_cursor[p]) + 1;
        res.x = tmp[psp_pkg::COORD_W-1:0];
        tmp = int'(page_shelf_top[p]) + 1;
        res.y = tmp[psp_pkg::COORD_W-1:0];
        page_cursor[p] = page_cursor[p] + bw[11:0];
        if (bh > int'(page_shelf_h[p]))
            page_shelf_h[p] = bh[11:0];
        return res;
    endfunction

    // random pause, none inside the periodic burst window
    function automatic bit take_break();
        if ((cyc % 6000) >= 5000)
            return 1'b0;
        return $urandom_range(99) < 20;
    endfunction

    function automatic void check_field(string name, int exp_val, int act_val);
        if (exp_val != act_val) begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_val, act_val);
            failed = 1'b1;
        end
    endfunction

    // request driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end else begin
            if (s_tvalid && s_tready)
                pending_results.insert(pending_results.size(), place_image(cur_req));
            if (!s_tvalid || s_tready) begin
                if (image_requests.size() != 0 && !take_break()) begin
                    cur_req = image_requests.pop_front();
                    s_tdata  <= {6'd0, cur_req};
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor and receiver back-pressure
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (pending_results.size() == 0) begin
                    $error("result transaction with no request outstanding");
                    failed = 1'b1;
                end else begin
                    want_res = pending_results.pop_front();
                    check_field("status", want_res.status, m_tuser);
                    check_field("page_index", want_res.page, m_tdata[3:0]);
                    check_field("atlas_x", want_res.x, m_tdata[14:4]);
                    check_field("atlas_y", want_res.y, m_tdata[25:15]);
                end
            end
            // one long hold-off so the block fills up and stalls its input
            if (hold_cnt > 0) begin
                hold_cnt--;
                m_tready <= 1'b0;
            end else if (!hold_done && results_seen == HOLD_AT) begin
                hold_done = 1'b1;
                hold_cnt  = HOLD_CYCLES;
                m_tready <= 1'b0;
            end else begin
                m_tready <= !take_break();
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge aclk) begin
        cyc++;
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet = 0;
        else
            quiet++;
        if (quiet >= STALL_LIMIT) begin
            $display("[multi_page_shelf_packer] ERROR");
            $finish;
        end
    end

    function automatic bit work_pending();
        return image_requests.size() != 0 || s_tvalid || pending_results.size() != 0;
    endfunction

    task automatic queue_image(int w, int h);
        image_req_t req;
        req.width  = w[psp_pkg::IMG_W-1:0];
        req.height = h[psp_pkg::IMG_W-1:0];
        image_requests.insert(image_requests.size(), req);
    endtask

    // mostly small sides, some up to and just past the limit, some noise
    function automatic int pick_side();
        int roll;
        int cap;
        roll = $urandom_range(99);
        cap = (side_limit < 64) ? int'(side_limit) : 63;
        if (roll < 60)
            return $urandom_range(cap);
        else if (roll < 80)
            return $urandom_range(side_limit);
        else if (roll < 88)
            return side_limit;
        else if (roll < 94)
            return int'(side_limit) + 1;
        return $urandom_range(8191);
    endfunction

    // random requests with occasional runs of one height to fill shelves
    task automatic queue_random_images(int count);
        int n;
        int run_left;
        int run_h;
        run_left = 0;
        run_h = 0;
        for (n = 0; n < count; n++) begin
            if (run_left == 0 && $urandom_range(99) < 15) begin
                run_left = $urandom_range(12, 4);
                run_h = pick_side();
            end
            if (run_left > 0) begin
                queue_image($urandom_range(side_limit), run_h);
                run_left--;
            end else begin
                queue_image(pick_side(), pick_side());
            end
        end
    endtask

    // register write once nothing is in flight
    task automatic write_side_limit(int value);
        while (work_pending())
            @(posedge aclk);
        @(posedge aclk);
        cfg_wen    <= 1'b1;
        cfg_wdata  <= value[10:0];
        side_limit = value[10:0];
        @(posedge aclk);
        cfg_wen    <= 1'b0;
    endtask

    // reset, stimulus phases and end of run
    initial begin
        int i;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // oversized requests, including all-ones and alternating bit patterns
        queue_image(8191, 8191);
        queue_image(513, 0);
        queue_image(0, 513);
        queue_image(5461, 2730);
        queue_image(2730, 5461);
        // three full shelves of largest boxes in page 0, then a second page
        for (i = 0; i < 10; i++)
            queue_image(512, 512);
        // leftover room on the last shelf, then a shelf move
        queue_image(400, 400);
        queue_image(200, 200);
        // zero size still takes a 2 by 2 box
        queue_image(0, 0);
        queue_image(1, 1);
        queue_image(512, 0);
        queue_image(0, 512);

        write_side_limit(1024);
        queue_random_images(350);

        write_side_limit(1);
        queue_random_images(150);

        write_side_limit($urandom_range(1023, 2));
        queue_random_images(550);

        // large limit again until pages run out
        write_side_limit(1024);
        queue_random_images(950);

        while (work_pending())
            @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (!failed)
            $display("[multi_page_shelf_packer] OK");
        else
            $display("[multi_page_shelf_packer] ERROR");
        $finish;
    end

endmodule
